/* rtl/core/sorted_four_entry_child_table_unit_macros.svh */
// assertion macros shared by the child table rtl
`ifndef SORTED_FOUR_ENTRY_CHILD_TABLE_UNIT_MACROS_SVH
`define SORTED_FOUR_ENTRY_CHILD_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// a holds in a cycle, so b holds in the same cycle
`define SFCT_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// a holds in a cycle, so b holds in the next cycle
`define SFCT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define SFCT_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg)

`define SFCT_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

/* rtl/core/sfct_pkg.sv */
`default_nettype none

package sfct_pkg;

    localparam int ENTRIES      = 4;
    localparam int KEY_W        = 8;
    localparam int VALUE_PORT_W = 64;
    localparam int POS_W        = 2;
    localparam int TOTAL_W      = 3;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                   mode;
        logic [KEY_W-1:0]        key;
        logic [VALUE_PORT_W-1:0] child_value;
        logic [POS_W-1:0]        position;
    } sfct_req_t;

    typedef struct packed {
        logic                    found;
        logic [POS_W-1:0]        match_position;
        logic [VALUE_PORT_W-1:0] match_value;
        status_t                 status;
        logic [TOTAL_W-1:0]      entry_total;
        logic [VALUE_PORT_W-1:0] first_value;
        logic [VALUE_PORT_W-1:0] last_value;
    } sfct_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/sfct_in_stage.sv */
`default_nettype none

module sfct_in_stage
    import sfct_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              mode,
    input  wire logic [KEY_W-1:0]        key,
    input  wire logic [VALUE_PORT_W-1:0] child_value,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic                    take,
    output logic                         req_valid,
    output sfct_req_t                    req
);

    logic      valid_reg;
    logic      valid_next;
    sfct_req_t req_reg;
    sfct_req_t req_next;
    logic      accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = accept || (valid_reg && !take);
        req_next.mode        = mode_t'(mode);
        req_next.key         = key;
        req_next.child_value = child_value;
        req_next.position    = position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

/* rtl/core/sfct_table.sv */
`default_nettype none

module sfct_table
    import sfct_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic update,
    input  sfct_req_t req,
    output sfct_rsp_t rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = $clog2(ENTRIES);

    logic [KEY_W-1:0]       keys_reg  [ENTRIES];
    logic [KEY_W-1:0]       keys_next [ENTRIES];
    logic [VALUE_WIDTH-1:0] vals_reg  [ENTRIES];
    logic [VALUE_WIDTH-1:0] vals_next [ENTRIES];
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;

    logic [KEY_W-1:0]       keys_prev [ENTRIES];
    logic [KEY_W-1:0]       keys_succ [ENTRIES];
    logic [VALUE_WIDTH-1:0] vals_prev [ENTRIES];
    logic [VALUE_WIDTH-1:0] vals_succ [ENTRIES];

    logic [ENTRIES-1:0]     occ;
    logic [ENTRIES-1:0]     hit;
    logic [ENTRIES-1:0]     hit_first;
    logic [ENTRIES-1:0]     gt;
    logic [ENTRIES-1:0]     last_sel;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       ins_at;
    logic [CNT_W-1:0]       pos_ext;
    logic                   any_hit;
    logic                   full;
    logic                   bad_pos;
    logic                   do_ins;
    logic                   do_rem;
    logic [VALUE_WIDTH-1:0] req_val;
    logic [VALUE_WIDTH-1:0] hit_val;
    logic [VALUE_WIDTH-1:0] first_val;
    logic [VALUE_WIDTH-1:0] last_val;

    // neighbor taps for the shift up on insert and down on remove
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_nbr
        if (g == 0)
        begin : g_lo
            assign keys_prev[g] = keys_reg[0];
            assign vals_prev[g] = vals_reg[0];
        end
        else
        begin : g_mid_lo
            assign keys_prev[g] = keys_reg[g-1];
            assign vals_prev[g] = vals_reg[g-1];
        end
        if (g == ENTRIES - 1)
        begin : g_hi
            assign keys_succ[g] = keys_reg[ENTRIES-1];
            assign vals_succ[g] = vals_reg[ENTRIES-1];
        end
        else
        begin : g_mid_hi
            assign keys_succ[g] = keys_reg[g+1];
            assign vals_succ[g] = vals_reg[g+1];
        end
    end

    // per-slot compares, lowest hit and first larger key
    always_comb
    begin
        any_hit   = 1'b0;
        hit_first = '0;
        hit_idx   = '0;
        ins_at    = IDX_W'(cnt_reg);
        hit_val   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            occ[i] = CNT_W'(i) < cnt_reg;
            hit[i] = occ[i] && (keys_reg[i] == req.key);
            gt[i]  = occ[i] && (req.key < keys_reg[i]);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit[i] && !any_hit)
            begin
                hit_first[i] = 1'b1;
                hit_idx      = IDX_W'(i);
                any_hit      = 1'b1;
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (gt[i])
            begin
                ins_at = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_val = hit_val | ({VALUE_WIDTH{hit_first[i]}} & vals_reg[i]);
        end
    end

    always_comb
    begin
        req_val  = VALUE_WIDTH'(req.child_value);
        pos_ext  = CNT_W'(req.position);
        full     = cnt_reg >= CNT_W'(ENTRIES);
        bad_pos  = pos_ext >= cnt_reg;
        do_ins   = (req.mode == MODE_INSERT) && !full;
        do_rem   = (req.mode == MODE_REMOVE) && !bad_pos;
        keys_next = keys_reg;
        vals_next = vals_reg;
        cnt_next  = cnt_reg;
        if (do_ins)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) == ins_at)
                begin
                    keys_next[i] = req.key;
                    vals_next[i] = req_val;
                end
                else if (IDX_W'(i) > ins_at)
                begin
                    keys_next[i] = keys_prev[i];
                    vals_next[i] = vals_prev[i];
                end
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CNT_W'(i) >= pos_ext)
                begin
                    keys_next[i] = keys_succ[i];
                    vals_next[i] = vals_succ[i];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        last_val  = '0;
        first_val = (cnt_next != '0) ? vals_next[0] : '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            last_sel[i] = cnt_next == CNT_W'(i + 1);
            last_val    = last_val | ({VALUE_WIDTH{last_sel[i]}} & vals_next[i]);
        end

        rsp.found          = 1'b0;
        rsp.match_position = '0;
        rsp.match_value    = '0;
        rsp.status         = ST_OK;
        rsp.entry_total    = TOTAL_W'(cnt_next);
        rsp.first_value    = VALUE_PORT_W'(first_val);
        rsp.last_value     = VALUE_PORT_W'(last_val);
        case (req.mode)
            MODE_FIND:
            begin
                rsp.found          = any_hit;
                rsp.match_position = POS_W'(hit_idx);
                rsp.match_value    = VALUE_PORT_W'(hit_val);
            end
            MODE_INSERT:
            begin
                rsp.status         = full ? ST_FULL : ST_OK;
                rsp.match_position = do_ins ? POS_W'(ins_at) : '0;
            end
            MODE_REMOVE:
            begin
                rsp.status         = bad_pos ? ST_BAD_POS : ST_OK;
                rsp.match_position = req.position;
            end
            default:
            begin
                rsp.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (update)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            keys_reg <= keys_next;
            vals_reg <= vals_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sfct_out_stage.sv */
`default_nettype none

module sfct_out_stage
    import sfct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  sfct_rsp_t rsp_in,
    input  wire logic out_ready,
    output logic      out_valid,
    output sfct_rsp_t rsp
);

    logic      valid_reg;
    logic      valid_next;
    sfct_rsp_t rsp_reg;

    // a held result leaves when taken, a new one may land in the same cycle
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/sorted_four_entry_child_table_unit.sv */
// Sorted child table: up to ENTRIES byte keys with child values, ascending by key.
// Input channel in_valid/in_ready carries mode, key, child_value and position;
// output channel out_valid/out_ready carries found, match_position, match_value,
// status, entry_total, first_value and last_value.
// Modes: find by key, insert key and value (equal keys go after their equals),
// remove at position. Full inserts and bad positions report a status and leave
// the table unchanged.
// An item is taken into an input register, then the compares, the shift of the
// slots and the result are formed combinationally into the result register.
// out_valid rises once the item moves from the input register into the result
// register, which waits while a held result is not taken; one item per cycle is
// sustained while out_ready stays high, as the table updates on that same move.
// Each item sees the table as left by the item before it.
// Reset empties the table and drops both registers; slot contents are not cleared.
// When the receiver stalls the result holds, the input register still takes
// one more item, and in_ready falls until the result is taken.
`default_nettype none

`include "sorted_four_entry_child_table_unit_macros.svh"

module sorted_four_entry_child_table_unit
    import sfct_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              mode,
    input  wire logic [KEY_W-1:0]        key,
    input  wire logic [VALUE_PORT_W-1:0] child_value,
    input  wire logic [POS_W-1:0]        position,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         found,
    output logic [POS_W-1:0]             match_position,
    output logic [VALUE_PORT_W-1:0]      match_value,
    output logic [1:0]                   status,
    output logic [TOTAL_W-1:0]           entry_total,
    output logic [VALUE_PORT_W-1:0]      first_value,
    output logic [VALUE_PORT_W-1:0]      last_value
);

    logic      req_valid;
    sfct_req_t req;
    sfct_rsp_t rsp_comb;
    sfct_rsp_t rsp;
    logic      advance;

    assign advance = req_valid && (!out_valid || out_ready);

    sfct_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .child_value (child_value),
        .position    (position),
        .take        (advance),
        .req_valid   (req_valid),
        .req         (req)
    );

    sfct_table #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .req    (req),
        .rsp    (rsp_comb)
    );

    sfct_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .rsp_in    (rsp_comb),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .rsp       (rsp)
    );

    assign found          = rsp.found;
    assign match_position = rsp.match_position;
    assign match_value    = rsp.match_value;
    assign status         = rsp.status;
    assign entry_total    = rsp.entry_total;
    assign first_value    = rsp.first_value;
    assign last_value     = rsp.last_value;

    `SFCT_ASSERT_IMPLIES(a_full_no_match, clk, rst_n,
        out_valid && (status == ST_FULL),
        !found && (match_position == '0) && (match_value == '0),
        "full insert reported a match")
    `SFCT_ASSERT_IMPLIES(a_found_ok, clk, rst_n,
        out_valid && found,
        status == ST_OK,
        "find hit with an error status")
    `SFCT_ASSERT_IMPLIES(a_miss_zero, clk, rst_n,
        out_valid && !found,
        match_value == '0,
        "match value set without a hit")
    `SFCT_ASSERT_NEXT(a_stall_holds_input, clk, rst_n,
        req_valid && out_valid && !out_ready,
        req_valid && out_valid,
        "input register dropped an item under stall")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sfct_pkg::*;

    localparam int TABLE_SLOTS  = 4;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 5;

    // mode 3 has no operation defined
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_style_t;

    class child_table_scoreboard;
        logic [KEY_W-1:0]        slot_key [TABLE_SLOTS];
        logic [VALUE_PORT_W-1:0] slot_val [TABLE_SLOTS];
        int unsigned             used;
        sfct_rsp_t               pending_results [$];
        int unsigned             mismatches;

        function new();
            used       = 0;
            mismatches = 0;
        endfunction

        function int unsigned entry_count();
            return used;
        endfunction

        function int unsigned waiting();
            return pending_results.size();
        endfunction

        // apply one accepted request to the shadow table and queue its result
        function void note_request(logic [1:0] op, logic [KEY_W-1:0] k,
                                   logic [VALUE_PORT_W-1:0] v, logic [POS_W-1:0] p);
            sfct_rsp_t   r;
            int unsigned at;
            int unsigned i;
            r = '0;
            if (op == MODE_FIND)
            begin
                for (i = 0; i < used; i++)
                begin
                    if (slot_key[i] == k)
                    begin
                        r.found          = 1'b1;
                        r.match_position = i[POS_W-1:0];
                        r.match_value    = slot_val[i];
                        break;
                    end
                end
            end
            else if (op == MODE_INSERT)
            begin
                if (used >= TABLE_SLOTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // equal keys land after their equals
                    at = used;
                    for (i = 0; i < used; i++)
                    begin
                        if (k < slot_key[i])
                        begin
                            at = i;
                            break;
                        end
                    end
                    for (i = used; i > at; i--)
                    begin
                        slot_key[i] = slot_key[i-1];
                        slot_val[i] = slot_val[i-1];
                    end
                    slot_key[at]     = k;
                    slot_val[at]     = v;
                    used++;
                    r.match_position = at[POS_W-1:0];
                end
            end
            else if (op == MODE_REMOVE)
            begin
                r.match_position = p;
                if (32'(p) >= used)
                begin
                    r.status = ST_BAD_POS;
                end
                else
                begin
                    for (i = 32'(p); i + 1 < used; i++)
                    begin
                        slot_key[i] = slot_key[i+1];
                        slot_val[i] = slot_val[i+1];
                    end
                    used--;
                end
            end
            r.entry_total = used[TOTAL_W-1:0];
            if (used > 0)
            begin
                r.first_value = slot_val[0];
                r.last_value  = slot_val[used-1];
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [VALUE_PORT_W-1:0] want_v,
                                    logic [VALUE_PORT_W-1:0] got_v);
            if (got_v !== want_v)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h, got %h",
                             $realtime, name, want_v, got_v);
            end
        endfunction

        function void check_result(sfct_rsp_t got);
            sfct_rsp_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: %h", $realtime, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("found", VALUE_PORT_W'(want.found), VALUE_PORT_W'(got.found));
            compare_field("match_position", VALUE_PORT_W'(want.match_position),
                          VALUE_PORT_W'(got.match_position));
            compare_field("match_value", want.match_value, got.match_value);
            compare_field("status", VALUE_PORT_W'(want.status), VALUE_PORT_W'(got.status));
            compare_field("entry_total", VALUE_PORT_W'(want.entry_total),
                          VALUE_PORT_W'(got.entry_total));
            compare_field("first_value", want.first_value, got.first_value);
            compare_field("last_value", want.last_value, got.last_value);
        endfunction
    endclass

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [1:0]              mode        = MODE_FIND;
    logic [KEY_W-1:0]        key         = '0;
    logic [VALUE_PORT_W-1:0] child_value = '0;
    logic [POS_W-1:0]        position    = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic                    found;
    logic [POS_W-1:0]        match_position;
    logic [VALUE_PORT_W-1:0] match_value;
    logic [1:0]              status;
    logic [TOTAL_W-1:0]      entry_total;
    logic [VALUE_PORT_W-1:0] first_value;
    logic [VALUE_PORT_W-1:0] last_value;

    child_table_scoreboard sb = new();

    int unsigned idle_cycles = 0;
    rx_style_t   rx_style    = RX_FREE;
    int unsigned rx_left     = 0;

    sorted_four_entry_child_table_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .key            (key),
        .child_value    (child_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .match_value    (match_value),
        .status         (status),
        .entry_total    (entry_total),
        .first_value    (first_value),
        .last_value     (last_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        sfct_rsp_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.found          = found;
            got.match_position = match_position;
            got.match_value    = match_value;
            got.status         = status_t'(status);
            got.entry_total    = entry_total;
            got.first_value    = first_value;
            got.last_value     = last_value;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("sorted_four_entry_child_table_unit verification failed");
                $finish;
            end
        end
    end

    // receiver switches at random between stall styles
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(20, 120);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_FREE:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:  out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= (rx_left % 3 == 0);
        endcase
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VALUE_PORT_W-1:0] v, input logic [POS_W-1:0] p);
        in_valid    = 1'b1;
        mode        = op;
        key         = k;
        child_value = v;
        position    = p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(op, k, v, p);
        @(negedge clk);
    endtask

    task automatic idle_for(input int unsigned n);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_all_results();
        in_valid = 1'b0;
        while (sb.waiting() != 0)
            @(negedge clk);
    endtask

    // biased toward legal traffic: inserts while sparse, removes while crowded
    task automatic send_random_item();
        int unsigned             n;
        int unsigned             roll;
        int unsigned             ins_pct;
        logic [1:0]              op;
        logic [KEY_W-1:0]        k;
        logic [VALUE_PORT_W-1:0] v;
        logic [POS_W-1:0]        p;
        n    = sb.entry_count();
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            op = MODE_NOP;
        end
        else if (roll < 30)
        begin
            op = MODE_FIND;
        end
        else
        begin
            ins_pct = (n == 0) ? 90 : (n == 1) ? 70 : (n == 2) ? 55 : (n == 3) ? 40 : 20;
            op = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
        end
        case ($urandom_range(0, 5))
            0:       k = 8'h00;
            1:       k = 8'hFF;
            2:       k = 8'h40 + KEY_W'($urandom_range(0, 3));
            3:       k = (n > 0) ? sb.slot_key[$urandom_range(0, n - 1)] : 8'h80;
            default: k = KEY_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        if (n > 0 && $urandom_range(0, 4) != 0)
            p = POS_W'($urandom_range(0, n - 1));
        else
            p = POS_W'($urandom_range(0, 3));
        send_item(op, k, v, p);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned j;
        bit          drained_once;
        sent         = 0;
        drained_once = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table: miss, bad positions, no-op
        send_item(MODE_FIND,   8'h00, '0, 2'd0);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd0);
        send_item(MODE_REMOVE, 8'hFF, '1, 2'd3);
        send_item(MODE_NOP,    8'hFF, '1, 2'd3);
        // fill with a repeated key, then overflow
        send_item(MODE_INSERT, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
        send_item(MODE_INSERT, 8'h00, 64'h0000_0000_0000_0001, 2'd0);
        send_item(MODE_INSERT, 8'hFF, 64'h5555_5555_5555_5555, 2'd1);
        send_item(MODE_INSERT, 8'h80, 64'hAAAA_AAAA_AAAA_AAAA, 2'd2);
        send_item(MODE_FIND,   8'h80, '0, 2'd0);
        send_item(MODE_FIND,   8'hFF, '0, 2'd0);
        send_item(MODE_FIND,   8'h00, '1, 2'd3);
        send_item(MODE_FIND,   8'h7F, '0, 2'd0);
        send_item(MODE_INSERT, 8'h10, 64'h1234_5678_9ABC_DEF0, 2'd0);
        send_item(MODE_NOP,    8'h00, '0, 2'd0);
        // drain from positions 3, 0 and 1, with removes past the end
        send_item(MODE_REMOVE, 8'h00, '0, 2'd3);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd3);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd0);
        send_item(MODE_FIND,   8'h80, '0, 2'd0);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd1);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd0);
        send_item(MODE_REMOVE, 8'h00, '0, 2'd0);
        send_item(MODE_FIND,   8'hFF, '0, 2'd0);
        wait_all_results();

        while (sent < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 16);
            for (j = 0; j < burst && sent < RANDOM_ITEMS; j++)
            begin
                send_random_item();
                sent++;
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2)
            begin
                wait_all_results();
                drained_once = 1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_for($urandom_range(1, 8));
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.waiting() == 0)
            $display("sorted_four_entry_child_table_unit verification clean");
        else
            $display("sorted_four_entry_child_table_unit verification failed");
        $finish;
    end

endmodule
